FILE: design/siph_pkg.sv
// Shared types and constants for the SipHash-2-4 stream core.
// Depends on nothing; every other design file imports it.
package siph_pkg;

  // SipHash initialization constants, XORed with the key halves.
  localparam logic [63:0] InitA = 64'h736f6d6570736575;
  localparam logic [63:0] InitB = 64'h646f72616e646f6d;
  localparam logic [63:0] InitC = 64'h6c7967656e657261;
  localparam logic [63:0] InitD = 64'h7465646279746573;

  // Constant XORed into lane c before the finalization rounds.
  localparam logic [63:0] FinalXor = 64'h00000000000000ff;

  // Width of the stream data bus: 64 data bits, 4 count bits, padded to bytes.
  localparam int unsigned InDataW = 72;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgKeyLow  = 2'd0,
    CfgKeyHigh = 2'd1
  } cfg_reg_e;

  // The four 64-bit SipHash lanes.
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } lanes_t;

  // Everything the finalization pipeline needs for one message.
  typedef struct packed {
    lanes_t      lanes;  // lanes before the last word
    logic [63:0] word;   // last word, absorbed only when full
    logic [63:0] block;  // length byte over the masked tail
    logic        full;   // last word carries all eight bytes
  } fin_req_t;

endpackage

FILE: design/siph_dround.sv
// Combinational compression step: XOR message into lane d, two SipRounds,
// XOR message into lane a. Uses siph_pkg for the lane type.
module siph_dround (
  input  siph_pkg::lanes_t lanes_i,
  input  logic [63:0]      msg_i,
  output siph_pkg::lanes_t lanes_o
);
  import siph_pkg::*;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

  function automatic lanes_t sip_round(input lanes_t l);
    lanes_t s;
    s = l;
    s.a = s.a + s.b;
    s.c = s.c + s.d;
    s.b = rotl(s.b, 13) ^ s.a;
    s.d = rotl(s.d, 16) ^ s.c;
    s.a = rotl(s.a, 32);
    s.c = s.c + s.b;
    s.a = s.a + s.d;
    s.b = rotl(s.b, 17) ^ s.c;
    s.d = rotl(s.d, 21) ^ s.a;
    s.c = rotl(s.c, 32);
    sip_round = s;
  endfunction

  lanes_t pre;
  lanes_t mid;
  lanes_t post;

  // Message in, two rounds, message out.
  always_comb begin
    pre     = lanes_i;
    pre.d   = lanes_i.d ^ msg_i;
    mid     = sip_round(pre);
    post    = sip_round(mid);
    lanes_o = post;
    lanes_o.a = post.a ^ msg_i;
  end

endmodule

FILE: design/siph_final.sv
// Finalization pipeline: optional full-word absorb, final block absorb,
// four closing rounds and the output register. Uses siph_pkg, siph_dround.
module siph_final (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  siph_pkg::fin_req_t req_i,
  output logic               hash_valid_o,
  input  logic               hash_ready_i,
  output logic [63:0]        hash_o
);
  import siph_pkg::*;

  // Stage registers.
  logic        v1_q, v2_q, v3_q, v4_q, vo_q;
  fin_req_t    s1_q;
  lanes_t      s2_lanes_q;
  logic [63:0] s2_block_q;
  lanes_t      s3_q;
  lanes_t      s4_q;
  logic [63:0] hash_q;

  logic        rdy1, rdy2, rdy3, rdy4, rdyo;
  lanes_t      word_abs;
  lanes_t      s1_out;
  lanes_t      blk_abs;
  lanes_t      s2_out;
  lanes_t      s3_out;
  lanes_t      s4_out;

  // Each stage moves when it is empty or the stage after it moves.
  assign rdyo = ~vo_q | hash_ready_i;
  assign rdy4 = ~v4_q | rdyo;
  assign rdy3 = ~v3_q | rdy4;
  assign rdy2 = ~v2_q | rdy3;
  assign rdy1 = ~v1_q | rdy2;
  assign req_ready_o = rdy1;

  // Stage 1: absorb a full last word, else pass the lanes on.
  siph_dround u_word (.lanes_i(s1_q.lanes), .msg_i(s1_q.word), .lanes_o(word_abs));
  assign s1_out = s1_q.full ? word_abs : s1_q.lanes;

  // Stage 2: absorb the final block and mark finalization in lane c.
  siph_dround u_block (.lanes_i(s2_lanes_q), .msg_i(s2_block_q), .lanes_o(blk_abs));
  always_comb begin
    s2_out   = blk_abs;
    s2_out.c = blk_abs.c ^ FinalXor;
  end

  // Stages 3 and 4: two closing rounds each.
  siph_dround u_fin_a (.lanes_i(s3_q), .msg_i('0), .lanes_o(s3_out));
  siph_dround u_fin_b (.lanes_i(s4_q), .msg_i('0), .lanes_o(s4_out));

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= req_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdyo) vo_q <= v4_q;
    end
  end

  // Payload registers load only when a transaction moves in.
  always_ff @(posedge clk_i) begin
    if (rdy1 && req_valid_i) s1_q <= req_i;
    if (rdy2 && v1_q) begin
      s2_lanes_q <= s1_out;
      s2_block_q <= s1_q.block;
    end
    if (rdy3 && v2_q) s3_q <= s2_out;
    if (rdy4 && v3_q) s4_q <= s3_out;
    if (rdyo && v4_q) hash_q <= s4_out.a ^ s4_out.b ^ s4_out.c ^ s4_out.d;
  end

  assign hash_valid_o = vo_q;
  assign hash_o       = hash_q;

endmodule

FILE: design/siphash_2_4_stream_core.sv
// SipHash-2-4 stream core: one 64-bit word per transaction. After the last word
// is accepted, the hash passes five register stages before it is valid on the
// output: four two-round stages (the first only for a full last word) and the
// output register. A word is accepted every cycle unless the finalization
// pipeline holds s_axis_tready low; the rate is set by the lane update loop,
// which runs two SipRounds per cycle. Reset (rst_ni, async, low) clears the key
// to zero, loads the lanes from it, clears the length and empties the pipeline.
// Top level; uses siph_pkg, siph_dround and siph_final.
module siphash_2_4_stream_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [63:0]                    cfg_data_i,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: data_word [63:0], valid_bytes [67:64], zero [71:68].
  input  logic [siph_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tlast,
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: hash_value [63:0].
  output logic [63:0]                    m_axis_tdata
);
  import siph_pkg::*;

  logic [63:0] key_lo_q, key_lo_d;
  logic [63:0] key_hi_q, key_hi_d;
  lanes_t      lanes_q, lanes_d;
  logic [7:0]  len_q, len_d;

  logic [63:0] word;
  logic [3:0]  vbytes;
  logic        full;
  logic        accept;
  logic [7:0]  len_fin;
  logic [63:0] tail;
  lanes_t      lanes_abs;
  lanes_t      lanes_init;
  fin_req_t    req;
  logic        req_ready;

  assign word   = s_axis_tdata[63:0];
  assign vbytes = s_axis_tdata[67:64];
  // Any count of eight or more means a full word.
  assign full   = vbytes[3];
  assign s_axis_tready = req_ready;
  assign accept = s_axis_tvalid & s_axis_tready;

  // Running compression of a non-final word.
  siph_dround u_abs (.lanes_i(lanes_q), .msg_i(word), .lanes_o(lanes_abs));

  // Final length and masked tail of the last word.
  always_comb begin
    len_fin = len_q + (full ? 8'd8 : {5'd0, vbytes[2:0]});
    tail    = '0;
    for (int b = 0; b < 8; b++) begin
      if (!full && (3'(b) < vbytes[2:0])) tail[b*8 +: 8] = word[b*8 +: 8];
    end
    req.lanes = lanes_q;
    req.word  = word;
    req.block = {len_fin, tail[55:0]};
    req.full  = full;
  end

  // Key writes, then lanes and length for the next cycle.
  always_comb begin
    key_lo_d = key_lo_q;
    key_hi_d = key_hi_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgKeyLow:  key_lo_d = cfg_data_i;
        CfgKeyHigh: key_hi_d = cfg_data_i;
        default: ;
      endcase
    end
    lanes_init.a = key_lo_d ^ InitA;
    lanes_init.b = key_hi_d ^ InitB;
    lanes_init.c = key_lo_d ^ InitC;
    lanes_init.d = key_hi_d ^ InitD;

    lanes_d = lanes_q;
    len_d   = len_q;
    if (cfg_we_i && ((cfg_idx_i == CfgKeyLow) || (cfg_idx_i == CfgKeyHigh))) begin
      lanes_d = lanes_init;
      len_d   = '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        lanes_d = lanes_init;
        len_d   = '0;
      end else begin
        lanes_d = lanes_abs;
        len_d   = len_q + 8'd8;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
      lanes_q  <= '{a: InitA, b: InitB, c: InitC, d: InitD};
      len_q    <= '0;
    end else begin
      key_lo_q <= key_lo_d;
      key_hi_q <= key_hi_d;
      lanes_q  <= lanes_d;
      len_q    <= len_d;
    end
  end

  // Finalization runs off to the side so the next message can start at once.
  siph_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid & s_axis_tlast),
    .req_ready_o  (req_ready),
    .req_i        (req),
    .hash_valid_o (m_axis_tvalid),
    .hash_ready_i (m_axis_tready),
    .hash_o       (m_axis_tdata)
  );

endmodule
